// File: rtl/core/encoder_speed_position_tracker_core_defines.svh
// Assertion macros for the encoder tracker core.
`ifndef ENCODER_SPEED_POSITION_TRACKER_CORE_DEFINES_SVH
`define ENCODER_SPEED_POSITION_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define ESPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("espt check failed");
`define ESPT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("espt check failed");
`else
`define ESPT_ASSERT(lbl, prop)
`define ESPT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/core/espt_pkg.sv
package espt_pkg;

  localparam int CNT_W     = 16;
  localparam int MOD_W     = 17;
  localparam int RES_W     = 16;
  localparam int SCALE_W   = 32;
  localparam int DELTA_W   = 17;
  localparam int SPEED_W   = 48;
  localparam int POS_W     = 32;
  localparam int ROUND_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // averaging window is a power of two
  localparam int AVG_SHIFT = 3;
  localparam int AVG_DEPTH = 1 << AVG_SHIFT;

  localparam int SUM_W  = DELTA_W + AVG_SHIFT;
  localparam int PROD_W = SUM_W + SCALE_W;
  localparam int QUO_W  = PROD_W + 1 - AVG_SHIFT;
  localparam int SAT_W  = (QUO_W > SPEED_W) ? QUO_W : SPEED_W;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};

  localparam logic [MOD_W-1:0]   MODULUS_RST = 17'd65536;
  localparam logic [RES_W-1:0]   RESOLUTION_RST = 16'd1024;
  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd402124;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd2;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;
    logic signed [POS_W-1:0]   angle;
    logic signed [ROUND_W-1:0] rounds;
  } espt_track_t;

endpackage

// File: rtl/core/espt_track.sv
`include "encoder_speed_position_tracker_core_defines.svh"

module espt_track
  import espt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [CNT_W-1:0]  counter_value,
  input  logic [MOD_W-1:0]  modulus,
  input  logic [RES_W-1:0]  resolution,
  output espt_track_t       track
);

  logic [CNT_W-1:0]          prev_r;
  logic signed [DELTA_W-1:0] hist_r [AVG_DEPTH];
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [POS_W-1:0]   angle_r, angle_nxt;
  logic signed [ROUND_W-1:0] round_r, round_nxt;

  logic signed [MOD_W+1:0]   raw, mod_s, half_s, wrapped;
  logic signed [POS_W-1:0]   acc_sum;
  logic signed [SUM_W-1:0]   hist_total;

  always_comb begin
    raw    = $signed({3'b000, counter_value}) - $signed({3'b000, prev_r});
    mod_s  = $signed({2'b00, modulus});
    half_s = $signed({3'b000, modulus[MOD_W-1:1]});
    priority if (raw > half_s) begin
      wrapped = raw - mod_s;
    end else if (raw < -half_s) begin
      wrapped = raw + mod_s;
    end else begin
      wrapped = raw;
    end
    delta_nxt = wrapped[DELTA_W-1:0];

    sum_nxt = sum_r + SUM_W'(delta_nxt) - SUM_W'(hist_r[AVG_DEPTH-1]);

    acc_sum = angle_r + POS_W'(delta_nxt);
    priority if ($signed({acc_sum[POS_W-1], acc_sum}) >
                 $signed({{(POS_W+1-RES_W){1'b0}}, resolution})) begin
      angle_nxt = acc_sum - $signed({{(POS_W-RES_W){1'b0}}, resolution});
      round_nxt = round_r + ROUND_W'(1);
    end else if (acc_sum[POS_W-1]) begin
      angle_nxt = acc_sum + $signed({{(POS_W-RES_W){1'b0}}, resolution});
      round_nxt = round_r - ROUND_W'(1);
    end else begin
      angle_nxt = acc_sum;
      round_nxt = round_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      delta_r <= '0;
      sum_r   <= '0;
      angle_r <= '0;
      round_r <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (load) begin
      prev_r    <= counter_value;
      delta_r   <= delta_nxt;
      sum_r     <= sum_nxt;
      angle_r   <= angle_nxt;
      round_r   <= round_nxt;
      hist_r[0] <= delta_nxt;
      for (int i = 1; i < AVG_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  assign track = '{delta: delta_r, sum: sum_r, angle: angle_r, rounds: round_r};

  always_comb begin
    hist_total = '0;
    for (int i = 0; i < AVG_DEPTH; i++) begin
      hist_total = hist_total + SUM_W'(hist_r[i]);
    end
  end

  `ESPT_ASSERT(a_sum_matches_history, (sum_r == hist_total))
  `ESPT_ASSERT(a_one_turn_per_word, load |=> (round_r == $past(round_r) || round_r == $past(round_r) + ROUND_W'(1) || round_r == $past(round_r) - ROUND_W'(1)))
  `ESPT_ASSERT(a_state_holds_idle, !load |=> ($stable(prev_r) && $stable(angle_r) && $stable(sum_r)))

endmodule

// File: rtl/core/espt_speed.sv
module espt_speed
  import espt_pkg::*;
(
  input  logic signed [SUM_W-1:0]   sum,
  input  logic [SCALE_W-1:0]        scale,
  output logic signed [SPEED_W-1:0] speed
);

  localparam logic [PROD_W:0] RND_ADD = (PROD_W+1)'(AVG_DEPTH / 2);

  logic               neg;
  logic [SUM_W-1:0]   mag;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    rnd;
  logic [SAT_W-1:0]   quo;
  logic [SPEED_W-1:0] clamped;

  always_comb begin
    neg  = sum[SUM_W-1];
    mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
    prod = PROD_W'(mag) * PROD_W'(scale);
    rnd  = {1'b0, prod} + RND_ADD;
    quo  = SAT_W'(rnd[PROD_W:AVG_SHIFT]);
    if (quo > SAT_W'(SPEED_MAX)) begin
      clamped = SPEED_MAX;
    end else begin
      clamped = quo[SPEED_W-1:0];
    end
    speed = neg ? $signed(-clamped) : $signed(clamped);
  end

endmodule

// File: rtl/core/encoder_speed_position_tracker_core.sv
// channel | ports                                           | dir
// in      | in_valid, in_stall, in_counter_value            | word in
// out     | out_valid, out_stall, out_count_delta, out_speed,| word out
//         | out_angle_position, out_round_count             |
// cfg     | cfg_wr_en, cfg_index, cfg_wdata                 | write only
//
// One word per cycle sustained while out_stall is low; a word passes the track register, then the result register.
// Wrap, running sum and angle correction sit before the track register;
// the 20x32 speed multiply and rounding sit before the result register.
// rst_n (sync, low) clears all history, angle, turn count and loads register defaults.
// out_stall backs up through both stages; in_stall is raised only when both are full.
`include "encoder_speed_position_tracker_core_defines.svh"

module encoder_speed_position_tracker_core
  import espt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CNT_W-1:0]          in_counter_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DELTA_W-1:0] out_count_delta,
  output logic signed [SPEED_W-1:0] out_speed,
  output logic signed [POS_W-1:0]   out_angle_position,
  output logic signed [ROUND_W-1:0] out_round_count,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  logic [MOD_W-1:0]   modulus_r;
  logic [RES_W-1:0]   resolution_r;
  logic [SCALE_W-1:0] scale_r;

  logic s1_valid_r, out_valid_r;
  logic out_ready, s1_ready, s1_load, out_load;

  espt_track_t              track;
  logic signed [SPEED_W-1:0] speed_nxt;

  logic signed [DELTA_W-1:0] delta_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic signed [POS_W-1:0]   angle_r;
  logic signed [ROUND_W-1:0] round_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= MODULUS_RST;
      resolution_r <= RESOLUTION_RST;
      scale_r      <= SCALE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODULUS:    modulus_r    <= cfg_wdata[MOD_W-1:0];
        REG_RESOLUTION: resolution_r <= cfg_wdata[RES_W-1:0];
        REG_SCALE:      scale_r      <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;
  assign s1_load   = in_valid && s1_ready;
  assign out_load  = s1_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  espt_track u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (s1_load),
    .counter_value (in_counter_value),
    .modulus       (modulus_r),
    .resolution    (resolution_r),
    .track         (track)
  );

  espt_speed u_speed (
    .sum   (track.sum),
    .scale (scale_r),
    .speed (speed_nxt)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      delta_r <= track.delta;
      speed_r <= speed_nxt;
      angle_r <= track.angle;
      round_r <= track.rounds;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_count_delta    = delta_r;
  assign out_speed          = speed_r;
  assign out_angle_position = angle_r;
  assign out_round_count    = round_r;

  `ESPT_ASSERT_ALWAYS(a_stall_only_when_full, in_stall |-> (s1_valid_r && out_valid_r))
  `ESPT_ASSERT(a_stage_moves_on, out_load |=> out_valid_r)

endmodule
